@@ rtl/lfle_pkg.sv @@
// Shared types, constants and slot encoding for the loop frame line encoder.
package lfle_pkg;

    // Frame and slot geometry
    localparam int FRAME_BITS      = 11;
    localparam int SYNC_SLOTS      = 6;
    localparam int SLOTS_PER_BIT   = 4;
    localparam int SLOTS_PER_FRAME = SYNC_SLOTS + (FRAME_BITS - 1) * SLOTS_PER_BIT;

    // Position of a slot inside one bit cell
    typedef enum logic [2:0] {
        PHASE_FIRST  = 3'b001,
        PHASE_SECOND = 3'b010,
        PHASE_IDLE   = 3'b100
    } slot_phase_t;

    // One input item: a loop frame with its parameter
    typedef struct packed {
        logic [2:0] frame_control;
        logic [7:0] frame_data;
        logic [7:0] param;
        logic [7:0] param_mask;
    } frame_item_t;

    // One result item: the wire levels of a single line slot
    typedef struct packed {
        logic pos_drive;
        logic neg_drive;
        logic last_slot;
    } slot_item_t;

    // Per-cell control from the chain controller
    typedef struct packed {
        logic load;
        logic shift;
    } cell_ctrl_t;

    // Build the 11-bit frame from an input item
    function automatic logic [FRAME_BITS-1:0] frame_assemble(frame_item_t item);
        return {item.frame_control, item.frame_data | (item.param & item.param_mask)};
    endfunction

    // Wire levels for one slot: a one drives pos then neg, a zero the reverse
    function automatic slot_item_t slot_encode(logic bit_val, slot_phase_t phase,
                                               logic is_last);
        slot_item_t s;
        s.last_slot = is_last;
        unique case (phase)
            PHASE_FIRST:
            begin
                s.pos_drive = bit_val;
                s.neg_drive = ~bit_val;
            end
            PHASE_SECOND:
            begin
                s.pos_drive = ~bit_val;
                s.neg_drive = bit_val;
            end
            PHASE_IDLE:
            begin
                s.pos_drive = 1'b0;
                s.neg_drive = 1'b0;
            end
            default:
            begin
                s.pos_drive = 1'b0;
                s.neg_drive = 1'b0;
            end
        endcase
        return s;
    endfunction

endpackage

@@ rtl/lfle_slot_cell.sv @@
// One cell of the slot chain: holds one line slot and passes it toward the head.
module lfle_slot_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lfle_pkg::cell_ctrl_t ctrl,
    input  lfle_pkg::slot_item_t load_slot,
    input  lfle_pkg::slot_item_t next_slot,
    input  logic                 next_valid,
    output lfle_pkg::slot_item_t slot,
    output logic                 valid
);

    lfle_pkg::slot_item_t slot_reg;
    lfle_pkg::slot_item_t slot_next;
    logic                 valid_reg;
    logic                 valid_next;

    // Load a fresh frame, else take the neighbor's slot on advance, else hold
    always_comb
    begin
        priority if (ctrl.load)
        begin
            slot_next  = load_slot;
            valid_next = 1'b1;
        end
        else if (ctrl.shift)
        begin
            slot_next  = next_slot;
            valid_next = next_valid;
        end
        else
        begin
            slot_next  = slot_reg;
            valid_next = valid_reg;
        end
    end

    // Valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Slot payload
    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

    assign slot  = slot_reg;
    assign valid = valid_reg;

endmodule

@@ rtl/loop_frame_line_encoder.sv @@
// Top level: expands each loop frame into 46 line slots through a chain of slot cells.
// The first slot of a frame is offered in the cycle after the frame item is taken.
// One slot leaves per cycle while slot_stall is low, from the 46-cell slot chain.
// A new frame is taken on the same edge that the last slot of the previous one leaves.
// Reset clears every cell's valid flag; the chain is empty and takes a frame at once.
module loop_frame_line_encoder (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  frame_valid,
    output logic                  frame_stall,
    input  lfle_pkg::frame_item_t frame_item,
    output logic                  slot_valid,
    input  logic                  slot_stall,
    output lfle_pkg::slot_item_t  slot_item
);

    localparam int Slots = lfle_pkg::SLOTS_PER_FRAME;

    logic [lfle_pkg::FRAME_BITS-1:0] frame_bits;
    lfle_pkg::cell_ctrl_t            ctrl;
    lfle_pkg::slot_item_t            cell_slot  [Slots];
    logic                            cell_valid [Slots];
    logic                            load;
    logic                            advance;

    // Assemble the frame from the incoming item
    assign frame_bits = lfle_pkg::frame_assemble(frame_item);

    // Take a frame when the chain is empty or only its last slot is leaving
    assign advance     = cell_valid[0] & ~slot_stall;
    assign frame_stall = cell_valid[0] & (cell_valid[1] | slot_stall);
    assign load        = frame_valid & ~frame_stall;

    assign ctrl.load  = load;
    assign ctrl.shift = advance;

    // Build the chain; each cell encodes its own slot of the frame on load
    for (genvar k = 0; k < Slots; k++)
    begin : g_cell
        localparam int  Rel     = (k < lfle_pkg::SYNC_SLOTS) ? 0 : k - lfle_pkg::SYNC_SLOTS;
        localparam int  BitPos  = (k < lfle_pkg::SYNC_SLOTS) ? lfle_pkg::FRAME_BITS - 1
                                  : lfle_pkg::FRAME_BITS - 2 - Rel / lfle_pkg::SLOTS_PER_BIT;
        localparam int  Sub     = (k < lfle_pkg::SYNC_SLOTS) ? k
                                  : Rel % lfle_pkg::SLOTS_PER_BIT;
        localparam bit  IsIdle  = (k < lfle_pkg::SYNC_SLOTS) ? (k >= 4) : (Sub >= 2);
        localparam bit  IsLast  = (k == Slots - 1);

        lfle_pkg::slot_phase_t phase;
        lfle_pkg::slot_item_t  load_slot;
        lfle_pkg::slot_item_t  next_slot;
        logic                  next_valid;

        assign phase = IsIdle ? lfle_pkg::PHASE_IDLE
                     : ((Sub % 2) == 0) ? lfle_pkg::PHASE_FIRST : lfle_pkg::PHASE_SECOND;
        assign load_slot = lfle_pkg::slot_encode(frame_bits[BitPos], phase, IsLast);

        if (k == Slots - 1)
        begin : g_tail
            assign next_slot  = '0;
            assign next_valid = 1'b0;
        end
        else
        begin : g_body
            assign next_slot  = cell_slot[k+1];
            assign next_valid = cell_valid[k+1];
        end

        lfle_slot_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .load_slot  (load_slot),
            .next_slot  (next_slot),
            .next_valid (next_valid),
            .slot       (cell_slot[k]),
            .valid      (cell_valid[k])
        );
    end

    // Drive the head cell out
    assign slot_valid = cell_valid[0];
    assign slot_item  = cell_slot[0];

    // A frame is only loaded into a chain holding at most its head slot
    a_load_on_empty: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> !cell_valid[1])
        else $error("frame loaded while chain still busy");

    // A loaded frame starts with a valid, non-final head slot
    a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> (cell_valid[0] && cell_valid[Slots-1] && !cell_slot[0].last_slot))
        else $error("load did not fill the chain");

    // The final slot is exactly the one with nothing behind it
    a_last_alone: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[0] |-> (cell_slot[0].last_slot == !cell_valid[1]))
        else $error("last slot marker out of step with chain");

    // The tail cell is valid only from a load until the chain first advances
    a_tail_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        cell_valid[Slots-1] && !$past(load) |-> $past(cell_valid[Slots-1]) && !$past(advance))
        else $error("tail cell valid without load");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the loop frame line encoder: frame items in, line slots out.
`timescale 1ns / 1ps

module testbench;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int RANDOM_ITEMS = 190;
    localparam int DRAIN_CYCLES = 20;

    // Expected line slots of every accepted frame, checked in order
    class slot_checker;
        lfle_pkg::slot_item_t expected_slots[$];
        int                   mismatches;

        function new();
            expected_slots = {};
            mismatches     = 0;
        endfunction

        // Queue one active pair: a one drives pos then neg, a zero the reverse
        function void push_pair(logic bit_val);
            lfle_pkg::slot_item_t s;
            s.last_slot = 1'b0;
            s.pos_drive = bit_val;
            s.neg_drive = ~bit_val;
            expected_slots.push_back(s);
            s.pos_drive = ~bit_val;
            s.neg_drive = bit_val;
            expected_slots.push_back(s);
        endfunction

        function void push_idle();
            lfle_pkg::slot_item_t s;
            s = '0;
            expected_slots.push_back(s);
            expected_slots.push_back(s);
        endfunction

        // Expand an accepted frame into its 46 slots
        function void note_frame(lfle_pkg::frame_item_t f);
            logic [lfle_pkg::FRAME_BITS-1:0] frame;
            int                              base;
            base  = expected_slots.size();
            frame = {f.frame_control, f.frame_data | (f.param & f.param_mask)};
            // sync: top bit pair twice, then idle
            push_pair(frame[lfle_pkg::FRAME_BITS-1]);
            push_pair(frame[lfle_pkg::FRAME_BITS-1]);
            push_idle();
            // remaining bits, MSB first
            for (int b = lfle_pkg::FRAME_BITS - 2; b >= 0; b--)
            begin
                push_pair(frame[b]);
                push_idle();
            end
            expected_slots[base + lfle_pkg::SLOTS_PER_FRAME - 1].last_slot = 1'b1;
        endfunction

        // Compare a delivered slot with the oldest expectation
        function void check_slot(lfle_pkg::slot_item_t got);
            lfle_pkg::slot_item_t want;
            if (expected_slots.size() == 0)
            begin
                $error("slot item with no frame pending: pos=%0b neg=%0b last=%0b",
                       got.pos_drive, got.neg_drive, got.last_slot);
                mismatches++;
                return;
            end
            want = expected_slots.pop_front();
            if (got.pos_drive !== want.pos_drive)
            begin
                $error("pos_drive: expected %0b, got %0b", want.pos_drive, got.pos_drive);
                mismatches++;
            end
            if (got.neg_drive !== want.neg_drive)
            begin
                $error("neg_drive: expected %0b, got %0b", want.neg_drive, got.neg_drive);
                mismatches++;
            end
            if (got.last_slot !== want.last_slot)
            begin
                $error("last_slot: expected %0b, got %0b", want.last_slot, got.last_slot);
                mismatches++;
            end
        endfunction

        function int pending();
            return expected_slots.size();
        endfunction
    endclass

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  frame_valid = 1'b0;
    logic                  frame_stall;
    lfle_pkg::frame_item_t frame_item  = '0;
    logic                  slot_valid;
    logic                  slot_stall  = 1'b0;
    lfle_pkg::slot_item_t  slot_item;

    slot_checker board;
    int          cycles     = 0;
    int          stall_left = 0;
    bit          stall_on   = 1'b1;

    loop_frame_line_encoder i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .frame_valid (frame_valid),
        .frame_stall (frame_stall),
        .frame_item  (frame_item),
        .slot_valid  (slot_valid),
        .slot_stall  (slot_stall),
        .slot_item   (slot_item)
    );

    always #10 clk = ~clk;

    // Mostly short gaps, now and then a long one
    function automatic int pick_gap(int long_max);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, long_max);
    endfunction

    // Stall the slot side at random; once a running stall ends, hold it low while stalls are off
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            slot_stall <= 1'b1;
            stall_left--;
        end
        else if (stall_on && $urandom_range(0, 2) == 0)
        begin
            slot_stall <= 1'b1;
            stall_left = pick_gap(20);
        end
        else
        begin
            slot_stall <= 1'b0;
        end
    end

    // Sample both handshakes at the rising edge; guard against a hang
    always @(posedge clk)
    begin
        cycles++;
        if (rst_n)
        begin
            if (frame_valid && !frame_stall)
                board.note_frame(frame_item);
            if (slot_valid && !slot_stall)
                board.check_slot(slot_item);
        end
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("testbench failed");
            $finish;
        end
    end

    // Offer one frame after a gap and hold it until taken
    task automatic send_frame(input logic [2:0] ctrl, input logic [7:0] data,
                              input logic [7:0] par, input logic [7:0] mask,
                              input int gap);
        @(negedge clk);
        if (gap > 0)
        begin
            frame_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        frame_valid               <= 1'b1;
        frame_item.frame_control  <= ctrl;
        frame_item.frame_data     <= data;
        frame_item.param          <= par;
        frame_item.param_mask     <= mask;
        do
            @(posedge clk);
        while (frame_stall);
    endtask

    initial
    begin
        logic [7:0] mask;
        bit         quiet;
        board = new();

        // Hold reset, then release it
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, every control value, masking and overlap
        send_fields_directed();

        // Random frames in stretches with and without idling
        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            quiet    = ((i / 30) % 3) == 1;
            stall_on = !quiet;
            case ($urandom_range(0, 7))
                0:       mask = 8'h00;
                1:       mask = 8'hFF;
                default: mask = 8'($urandom);
            endcase
            send_frame(3'($urandom), 8'($urandom), 8'($urandom), mask,
                       quiet ? 0 : pick_gap(60));
        end
        @(negedge clk);
        frame_valid <= 1'b0;
        stall_on = 1'b1;

        // Drain the expected slots, then keep clocking before the verdict
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (board.mismatches == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    task automatic send_fields_directed();
        // all zeros and all ones
        send_frame(3'd0, 8'h00, 8'h00, 8'h00, 0);
        send_frame(3'd7, 8'hFF, 8'hFF, 8'hFF, 0);
        // every control value, back to back, with alternating data
        for (int c = 0; c < 8; c++)
            send_frame(3'(c), (c % 2) ? 8'hAA : 8'h55, 8'h00, 8'h00, 0);
        // parameter outside the mask is dropped
        send_frame(3'd4, 8'h00, 8'hFF, 8'h00, 2);
        send_frame(3'd3, 8'h00, 8'hF0, 8'h0F, 0);
        // parameter inside the mask sets data bits
        send_frame(3'd1, 8'h00, 8'hFF, 8'hFF, 1);
        send_frame(3'd6, 8'h01, 8'h80, 8'h80, 0);
        // overlap keeps set data bits set
        send_frame(3'd2, 8'hF0, 8'hFF, 8'hFF, 0);
        send_frame(3'd5, 8'hFF, 8'h00, 8'hFF, 5);
        send_frame(3'd0, 8'h0F, 8'h3C, 8'hC3, 0);
        // single bits and their complements across param and mask
        send_frame(3'd4, 8'h00, 8'h01, 8'h01, 0);
        send_frame(3'd0, 8'h80, 8'h7F, 8'hFE, 45);
        send_frame(3'd7, 8'h00, 8'h00, 8'h00, 0);
    endtask

endmodule
